>>> rtl/cms_pkg.sv
package cms_pkg;

  localparam int MaxMembers = 64;
  localparam int CoordBits  = 10;
  localparam int FracBits   = 8;
  localparam int IdxBits    = 6;
  localparam int CntBits    = 7;
  localparam int TotBits    = 25;
  // squared distance, padded to a whole number of digit pairs
  localparam int SqBits     = 2 * CoordBits + 2;
  // root has CoordBits+1 integer bits plus FracBits fraction
  localparam int RootBits   = CoordBits + 1 + FracBits;
  localparam int RemBits    = RootBits + 2;
  localparam int RootSteps  = RootBits;
  localparam logic [TotBits-1:0] TotMax = '1;

  typedef struct packed {
    logic [CoordBits-1:0] point_x;
    logic [CoordBits-1:0] point_y;
    logic                 last_point;
  } in_req_t;

  typedef struct packed {
    logic [CoordBits-1:0] medoid_x;
    logic [CoordBits-1:0] medoid_y;
    logic [IdxBits-1:0]   medoid_index;
    logic [TotBits-1:0]   distance_total;
    logic                 overflowed;
  } out_res_t;

  // data carried from cell to cell of the root chain
  typedef struct packed {
    logic                vld;
    logic                last;
    logic [SqBits-1:0]   val;
    logic [RemBits-1:0]  rem;
    logic [RootBits-1:0] root;
  } cell_bus_t;

endpackage

>>> rtl/cms_root_cell.sv
// One digit of the bit-serial square root, registered.
module cms_root_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [5:0]          step_i,
  input  cms_pkg::cell_bus_t  d_i,
  output cms_pkg::cell_bus_t  d_o
);
  import cms_pkg::*;

  logic [1:0]         pair;
  logic [RemBits-1:0] rem_sh, trial;
  cell_bus_t          q_nxt, q_r;

  always_comb begin
    pair = 2'b00;
    if (step_i < 6'(SqBits / 2)) begin
      pair = d_i.val[SqBits-1 -: 2];
    end
    rem_sh = {d_i.rem[RemBits-3:0], pair};
    trial  = {d_i.root[RootBits-1:0], 2'b01};
    q_nxt      = d_i;
    q_nxt.val  = {d_i.val[SqBits-3:0], 2'b00};
    if (rem_sh >= trial) begin
      q_nxt.rem  = rem_sh - trial;
      q_nxt.root = {d_i.root[RootBits-2:0], 1'b1};
    end else begin
      q_nxt.rem  = rem_sh;
      q_nxt.root = {d_i.root[RootBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r.vld <= d_i.vld;
    end
    q_r.last <= d_i.last;
    q_r.val  <= q_nxt.val;
    q_r.rem  <= q_nxt.rem;
    q_r.root <= q_nxt.root;
  end

  assign d_o = q_r;
endmodule

>>> rtl/cluster_medoid_select_top.sv
// A cluster's result follows its last request once every pair distance has passed the root chain.
// Throughput: one request per cycle while loading; the medoid search sends one
// pair distance into the 19-cell root chain each cycle; busy refuses requests meanwhile.
// Reset (rst_n, synchronous, active low) empties the cluster; the point store
// is not cleared. Results are strobed for one cycle; the receiver cannot stall.
module cluster_medoid_select_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cms_pkg::in_req_t  in_req,
  output logic              out_valid,
  output cms_pkg::out_res_t out_res
);
  import cms_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001, ST_RUN = 3'b010, ST_DONE = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CoordBits*2-1:0] store [MaxMembers];
  logic [CntBits-1:0]   count_r;
  logic                 ovf_r;
  logic [IdxBits-1:0]   j_r, k_r;
  logic                 issue_r;
  logic [CoordBits*2-1:0] pa_r, pb_r;
  logic                 pv_r, plast_r;
  logic [SqBits-1:0]    sq_r;
  logic                 sv_r, slast_r;
  logic [IdxBits-1:0]   sj_r, pj_r;
  logic [TotBits:0]     sum_r;
  logic [TotBits-1:0]   best_r;
  logic [IdxBits-1:0]   bidx_r;
  logic                 fin_r;
  logic                 accept;
  cell_bus_t            chain [RootSteps+1];
  logic [IdxBits-1:0]   jpipe [RootSteps+1];
  logic [CoordBits-1:0] dx, dy;

  function automatic logic [TotBits-1:0] sat(input logic [TotBits:0] a,
                                             input logic [RootBits-1:0] b);
    logic [TotBits+1:0] s;
    s = {1'b0, a} + (TotBits+2)'(b);
    return (s > (TotBits+2)'(TotMax)) ? TotMax : s[TotBits-1:0];
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r != ST_LOAD);

  // store writes and reads; port a fetches the medoid once the search is over
  always_ff @(posedge clk) begin
    if (accept && count_r < CntBits'(MaxMembers)) begin
      store[count_r[IdxBits-1:0]] <= {in_req.point_y, in_req.point_x};
    end
    pa_r <= store[issue_r ? j_r : bidx_r];
    pb_r <= store[k_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (accept && in_req.last_point) state_nxt = ST_RUN;
      ST_RUN:  if (fin_r) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // squared distance stage
  always_comb begin
    dx = (pa_r[CoordBits-1:0] > pb_r[CoordBits-1:0]) ?
         pa_r[CoordBits-1:0] - pb_r[CoordBits-1:0] : pb_r[CoordBits-1:0] - pa_r[CoordBits-1:0];
    dy = (pa_r[2*CoordBits-1:CoordBits] > pb_r[2*CoordBits-1:CoordBits]) ?
         pa_r[2*CoordBits-1:CoordBits] - pb_r[2*CoordBits-1:CoordBits] :
         pb_r[2*CoordBits-1:CoordBits] - pa_r[2*CoordBits-1:CoordBits];
  end

  always_ff @(posedge clk) begin
    sq_r <= SqBits'(dx) * SqBits'(dx) + SqBits'(dy) * SqBits'(dy);
    sj_r <= pj_r;
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      issue_r <= 1'b0;
      j_r     <= '0;
      k_r     <= '0;
      pv_r    <= 1'b0;
      sv_r    <= 1'b0;
      sum_r   <= '0;
      best_r  <= TotMax;
      bidx_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= 1'b0;
      if (accept) begin
        if (count_r < CntBits'(MaxMembers)) count_r <= count_r + 1'b1;
        else ovf_r <= 1'b1;
        if (in_req.last_point) begin
          issue_r <= 1'b1;
          j_r     <= '0;
          k_r     <= '0;
        end
      end
      // pair issue: j outer, k inner
      pv_r    <= issue_r;
      plast_r <= issue_r && ({1'b0, k_r} == count_r - 1'b1);
      pj_r    <= j_r;
      if (issue_r) begin
        if ({1'b0, k_r} == count_r - 1'b1) begin
          k_r <= '0;
          if ({1'b0, j_r} == count_r - 1'b1) issue_r <= 1'b0;
          else j_r <= j_r + 1'b1;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
      sv_r    <= pv_r;
      slast_r <= plast_r;
      // accumulate chain output
      if (chain[RootSteps].vld) begin
        if (chain[RootSteps].last) begin
          if (sat(sum_r, chain[RootSteps].root) < best_r) begin
            best_r <= sat(sum_r, chain[RootSteps].root);
            bidx_r <= jpipe[RootSteps];
          end
          sum_r <= '0;
          if (jpipe[RootSteps] == IdxBits'(count_r - 1'b1)) fin_r <= 1'b1;
        end else begin
          sum_r <= {1'b0, sat(sum_r, chain[RootSteps].root)};
        end
      end
      if (state_r == ST_DONE) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        best_r  <= TotMax;
        bidx_r  <= '0;
      end
    end
  end

  // root chain
  assign chain[0] = '{vld: sv_r, last: slast_r, val: sq_r, rem: '0, root: '0};
  assign jpipe[0] = sj_r;
  for (genvar g = 0; g < RootSteps; g++) begin : g_cell
    cms_root_cell u_cell (
      .clk(clk), .rst_n(rst_n), .step_i(6'(g)), .d_i(chain[g]), .d_o(chain[g+1])
    );
    always_ff @(posedge clk) jpipe[g+1] <= jpipe[g];
  end

  // result: store read of the medoid lands in DONE
  assign out_valid = (state_r == ST_DONE);
  always_comb begin
    out_res.medoid_x       = pa_r[CoordBits-1:0];
    out_res.medoid_y       = pa_r[2*CoordBits-1:CoordBits];
    out_res.medoid_index   = bidx_r;
    out_res.distance_total = best_r;
    out_res.overflowed     = ovf_r;
  end
endmodule
